// ===== sv/bine_pkg.sv =====
// ----------------------------------------------------------------------------
// B+ tree internal node engine - shared definitions
// Sizes, operation and result codes, and the store and result bundles.
// ----------------------------------------------------------------------------
package bine_pkg;

  localparam int KEY_SLOTS   = 16;
  localparam int KEY_BITS    = 16;
  localparam int CHILD_BITS  = 32;

  // one spare key slot and one spare child slot hold the merged node on split
  localparam int KEY_DEPTH   = KEY_SLOTS + 1;
  localparam int CHILD_DEPTH = KEY_SLOTS + 2;
  localparam int KIDX_W      = $clog2(KEY_DEPTH);
  localparam int CIDX_W      = $clog2(CHILD_DEPTH);
  localparam int CNT_W       = $clog2(KEY_SLOTS + 1);

  localparam int MID         = (KEY_SLOTS + 1) / 2;
  localparam int RIGHT_N     = KEY_SLOTS / 2;
  localparam int EMIT_W      = $clog2(RIGHT_N + 1);

  localparam int OP_W        = 2;
  localparam int KIND_W      = 3;

  localparam int IN_DATA_W   = ((KEY_BITS + CHILD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((KEY_BITS + CHILD_BITS + CNT_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INIT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SPLIT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd4;

  typedef struct packed {
    logic                  key_we;
    logic [KIDX_W-1:0]     key_waddr;
    logic [KEY_BITS-1:0]   key_wdata;
    logic [KIDX_W-1:0]     key_raddr;
    logic                  child_we;
    logic [CIDX_W-1:0]     child_waddr;
    logic [CHILD_BITS-1:0] child_wdata;
    logic [CIDX_W-1:0]     child_raddr;
  } store_req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [CHILD_BITS-1:0] child;
  } store_rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [KEY_BITS-1:0]   key;
    logic [CHILD_BITS-1:0] child;
    logic [CNT_W-1:0]      count;
    logic                  last;
  } res_t;

endpackage

// ===== sv/btree_internal_node_engine_top.sv =====
// ----------------------------------------------------------------------------
// B+ tree internal node engine
// Holds one internal node; init, upper-bound lookup, sorted insert and split.
//
//   channel | dir | tdata (low bit up)          | tuser     | tlast
//   s_axis  | in  | key[15:0], child[47:16]     | op[1:0]   | -
//   m_axis  | out | out_key[15:0],              | kind[2:0] | last
//           |     | out_child[47:16],           |           |
//           |     | count_now[52:48], zero pad  |           |
//
// One transfer in at a time; s_axis_tready is low while the sequencer works.
// Lookup and insert compare keys from the top down: one compare per stored
// key greater than the key, plus one for the first key that is not greater,
// if any; each compare waits for the registered read of the key memory.
// Split gives 9 results in place of the one result, each after its own
// registered read. Results wait in an output register; m_axis_tready low
// stalls the sequencer only once that register is full.
// Reset clears the key count; no clearing pass.
// ----------------------------------------------------------------------------
module btree_internal_node_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bine_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // key, child
  input  logic [bine_pkg::OP_W-1:0]           s_axis_tuser,  // op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bine_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // out_key, out_child, count_now
  output logic [bine_pkg::KIND_W-1:0]         m_axis_tuser,  // kind
  output logic                                m_axis_tlast
);

  bine_pkg::store_req_t req;
  bine_pkg::store_rsp_t rsp;
  bine_pkg::res_t       res;
  bine_pkg::res_t       out_q;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid_q;

  bine_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_key_i    (s_axis_tdata[bine_pkg::KEY_BITS-1:0]),
    .in_child_i  (s_axis_tdata[bine_pkg::KEY_BITS +: bine_pkg::CHILD_BITS]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .req_o       (req),
    .rsp_i       (rsp)
  );

  bine_store u_store (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bine_pkg::OUT_DATA_W'({out_q.count, out_q.child, out_q.key});
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== sv/bine_store.sv =====
// ----------------------------------------------------------------------------
// B+ tree node store
// Key and child memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module bine_store (
  input  logic                clk_i,
  input  bine_pkg::store_req_t req_i,
  output bine_pkg::store_rsp_t rsp_o
);

  logic [bine_pkg::KEY_BITS-1:0]   key_mem   [bine_pkg::KEY_DEPTH];
  logic [bine_pkg::CHILD_BITS-1:0] child_mem [bine_pkg::CHILD_DEPTH];
  logic [bine_pkg::KEY_BITS-1:0]   key_rd_q;
  logic [bine_pkg::CHILD_BITS-1:0] child_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem[req_i.key_waddr] <= req_i.key_wdata;
    end
    key_rd_q <= key_mem[req_i.key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.child_we) begin
      child_mem[req_i.child_waddr] <= req_i.child_wdata;
    end
    child_rd_q <= child_mem[req_i.child_raddr];
  end

  assign rsp_o.key   = key_rd_q;
  assign rsp_o.child = child_rd_q;

endmodule

// ===== sv/bine_ctrl.sv =====
// ----------------------------------------------------------------------------
// B+ tree node sequencer
// Downward scan with one shared compare: handles init, finds the upper bound,
// shifts entries up for insert, places the new entry and streams out a split.
// ----------------------------------------------------------------------------
module bine_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bine_pkg::OP_W-1:0]         in_op_i,
  input  logic [bine_pkg::KEY_BITS-1:0]     in_key_i,
  input  logic [bine_pkg::CHILD_BITS-1:0]   in_child_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output bine_pkg::res_t                    res_o,
  output bine_pkg::store_req_t              req_o,
  input  bine_pkg::store_rsp_t              rsp_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_LOOK_RD,
    S_LOOK_OUT,
    S_RESULT,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  state_e                              state_q, state_d;
  logic [bine_pkg::OP_W-1:0]           op_q, op_d;
  logic [bine_pkg::KEY_BITS-1:0]       key_q, key_d;
  logic [bine_pkg::CHILD_BITS-1:0]     child_q, child_d;
  logic [bine_pkg::KIDX_W-1:0]         idx_q, idx_d;
  logic [bine_pkg::CNT_W-1:0]          count_q, count_d;
  logic                                full_q, full_d;
  logic [bine_pkg::EMIT_W-1:0]         emit_q, emit_d;
  logic [bine_pkg::KIND_W-1:0]         kind_q, kind_d;
  logic                                emit_sel;
  state_e                              done_state;

  assign emit_sel   = (state_q == S_EMIT_RD) || (state_q == S_EMIT_OUT);
  assign done_state = (op_q == bine_pkg::OP_LOOKUP) ? S_LOOK_RD : S_PLACE;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    child_d = child_q;
    idx_d   = idx_q;
    count_d = count_q;
    full_d  = full_q;
    emit_d  = emit_q;
    kind_d  = kind_q;

    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.count = count_q;

    req_o = '0;
    if (emit_sel) begin
      req_o.key_raddr   = bine_pkg::KIDX_W'(bine_pkg::MID) + bine_pkg::KIDX_W'(emit_q);
      req_o.child_raddr = bine_pkg::CIDX_W'(bine_pkg::MID + 1) + bine_pkg::CIDX_W'(emit_q);
    end else begin
      req_o.key_raddr   = idx_q - bine_pkg::KIDX_W'(1);
      req_o.child_raddr = bine_pkg::CIDX_W'(idx_q);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op_i;
          key_d   = in_key_i;
          child_d = in_child_i;
          idx_d   = bine_pkg::KIDX_W'(count_q);
          full_d  = (count_q == bine_pkg::CNT_W'(bine_pkg::KEY_SLOTS));
          case (in_op_i) inside
            bine_pkg::OP_INIT: begin
              req_o.child_we    = 1'b1;
              req_o.child_waddr = '0;
              req_o.child_wdata = in_child_i;
              count_d           = '0;
              kind_d            = bine_pkg::KIND_INIT;
              state_d           = S_RESULT;
            end
            bine_pkg::OP_LOOKUP, bine_pkg::OP_INSERT: begin
              if (count_q == '0) begin
                state_d = (in_op_i == bine_pkg::OP_LOOKUP) ? S_LOOK_RD : S_PLACE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (rsp_i.key > key_q) begin
          if (op_q == bine_pkg::OP_INSERT) begin
            req_o.key_we      = 1'b1;
            req_o.key_waddr   = idx_q;
            req_o.key_wdata   = rsp_i.key;
            req_o.child_we    = 1'b1;
            req_o.child_waddr = bine_pkg::CIDX_W'(idx_q) + bine_pkg::CIDX_W'(1);
            req_o.child_wdata = rsp_i.child;
          end
          idx_d   = idx_q - bine_pkg::KIDX_W'(1);
          state_d = (idx_q == bine_pkg::KIDX_W'(1)) ? done_state : S_SCAN_RD;
        end else begin
          state_d = done_state;
        end
      end
      S_PLACE: begin
        req_o.key_we      = 1'b1;
        req_o.key_waddr   = idx_q;
        req_o.key_wdata   = key_q;
        req_o.child_we    = 1'b1;
        req_o.child_waddr = bine_pkg::CIDX_W'(idx_q) + bine_pkg::CIDX_W'(1);
        req_o.child_wdata = child_q;
        if (full_q) begin
          count_d = bine_pkg::CNT_W'(bine_pkg::MID);
          emit_d  = '0;
          state_d = S_EMIT_RD;
        end else begin
          count_d = count_q + bine_pkg::CNT_W'(1);
          kind_d  = bine_pkg::KIND_INSERT;
          state_d = S_RESULT;
        end
      end
      S_LOOK_RD: state_d = S_LOOK_OUT;
      S_LOOK_OUT: begin
        res_valid_o = 1'b1;
        res_o.kind  = bine_pkg::KIND_LOOKUP;
        res_o.child = rsp_i.child;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
        res_o.kind  = kind_q;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_RD: state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        res_valid_o = 1'b1;
        res_o.kind  = (emit_q == '0) ? bine_pkg::KIND_SPLIT : bine_pkg::KIND_RIGHT;
        res_o.key   = rsp_i.key;
        res_o.child = rsp_i.child;
        res_o.last  = (emit_q == bine_pkg::EMIT_W'(bine_pkg::RIGHT_N));
        if (res_ready_i) begin
          if (emit_q == bine_pkg::EMIT_W'(bine_pkg::RIGHT_N)) begin
            state_d = S_IDLE;
          end else begin
            emit_d  = emit_q + bine_pkg::EMIT_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      key_q   <= '0;
      child_q <= '0;
      idx_q   <= '0;
      count_q <= '0;
      full_q  <= 1'b0;
      emit_q  <= '0;
      kind_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      key_q   <= key_d;
      child_q <= child_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      full_q  <= full_d;
      emit_q  <= emit_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== verif/btree_internal_node_engine_checker.sv =====
// ----------------------------------------------------------------------------
// B+ tree internal node engine - stream checker
// Watches both stream channels and keeps its own copy of the node. Each input
// transfer applies its op to that copy and queues its due results. Each
// output transfer is compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module btree_internal_node_engine_checker
  import bine_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // key, child
  input  logic [OP_W-1:0]       s_tuser_i,   // op
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,   // out_key, out_child, count_now
  input  logic [KIND_W-1:0]     m_tuser_i,   // kind
  input  logic                  m_tlast_i,
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPLIT_AT  = (KEY_SLOTS + 1) / 2;
  localparam int RIGHT_CNT = KEY_SLOTS / 2;

  logic [KEY_BITS-1:0]   node_key   [KEY_SLOTS];
  logic [CHILD_BITS-1:0] node_child [KEY_SLOTS+1];
  int                    node_count;
  res_t                  due_results [$];
  int                    fails;

  function automatic int upper_pos(logic [KEY_BITS-1:0] key, int n);
    int p;
    p = 0;
    while (p < n && node_key[p] <= key) p++;
    return p;
  endfunction

  function automatic void queue_result(logic [KIND_W-1:0] kind, logic [KEY_BITS-1:0] key,
                                       logic [CHILD_BITS-1:0] child, int cnt, logic last);
    res_t r;
    r.kind  = kind;
    r.key   = key;
    r.child = child;
    r.count = CNT_W'(cnt);
    r.last  = last;
    due_results.push_back(r);
  endfunction

  task automatic apply_node_op(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                               logic [CHILD_BITS-1:0] child);
    logic [KEY_BITS-1:0]   mk [KEY_SLOTS+1];
    logic [CHILD_BITS-1:0] mc [KEY_SLOTS+2];
    int                    pos;
    case (op)
      OP_INIT: begin
        node_count    = 0;
        node_child[0] = child;
        queue_result(KIND_INIT, '0, '0, 0, 1'b1);
      end
      OP_LOOKUP: begin
        pos = upper_pos(key, node_count);
        queue_result(KIND_LOOKUP, '0, node_child[pos], node_count, 1'b1);
      end
      OP_INSERT: begin
        pos = upper_pos(key, node_count);
        if (node_count < KEY_SLOTS) begin
          for (int i = node_count; i > pos; i--) node_key[i] = node_key[i-1];
          node_key[pos] = key;
          for (int i = node_count + 1; i > pos + 1; i--) node_child[i] = node_child[i-1];
          node_child[pos+1] = child;
          node_count++;
          queue_result(KIND_INSERT, '0, '0, node_count, 1'b1);
        end else begin
          // merged node of KEY_SLOTS+1 keys, cut at the middle key
          for (int i = 0; i <= KEY_SLOTS; i++)
            mk[i] = (i < pos) ? node_key[i] : (i == pos) ? key : node_key[i-1];
          for (int i = 0; i <= KEY_SLOTS + 1; i++)
            mc[i] = (i <= pos) ? node_child[i] : (i == pos + 1) ? child : node_child[i-1];
          for (int i = 0; i < SPLIT_AT; i++) node_key[i] = mk[i];
          for (int i = 0; i <= SPLIT_AT; i++) node_child[i] = mc[i];
          node_count = SPLIT_AT;
          queue_result(KIND_SPLIT, mk[SPLIT_AT], mc[SPLIT_AT+1], SPLIT_AT, RIGHT_CNT == 0);
          for (int i = 0; i < RIGHT_CNT; i++)
            queue_result(KIND_RIGHT, mk[SPLIT_AT+1+i], mc[SPLIT_AT+2+i], SPLIT_AT,
                         i == RIGHT_CNT - 1);
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      node_count = 0;
      fails      = 0;
      due_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: kind 0x%0h data 0x%0h",
                 m_tuser_i, m_tdata_i);
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, m_tuser_i);
          check_field("out_key", want.key, m_tdata_i[KEY_BITS-1:0]);
          check_field("out_child", want.child, m_tdata_i[KEY_BITS +: CHILD_BITS]);
          check_field("count_now", want.count, m_tdata_i[KEY_BITS+CHILD_BITS +: CNT_W]);
          check_field("last", want.last, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i)
        apply_node_op(s_tuser_i, s_tdata_i[KEY_BITS-1:0], s_tdata_i[KEY_BITS +: CHILD_BITS]);
      errors_o  <= fails;
      pending_o <= due_results.size();
    end
  end

endmodule

// ===== verif/tb_btree_internal_node_engine_top.sv =====
// ----------------------------------------------------------------------------
// B+ tree internal node engine - testbench top
// Drives init, lookup, insert, split and ignored ops into the node engine with
// random gaps and output back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_btree_internal_node_engine_top;
  import bine_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int LONG_STALL      = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  int   fail_count;
  int   pending_count;
  int   tx_idle_pct = 18;
  int   rx_idle_pct = 50;
  logic long_stall_req = 1'b0;

  always #5 clk_i = ~clk_i;

  btree_internal_node_engine_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  btree_internal_node_engine_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .m_tuser_i (m_axis_tuser),
    .m_tlast_i (m_axis_tlast),
    .errors_o  (fail_count),
    .pending_o (pending_count)
  );

  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                           logic [CHILD_BITS-1:0] child);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({child, key});
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // receiver back-pressure, with one long hold-off on request
  initial begin : rx_ready_gen
    int   stall_left;
    logic stall_taken;
    stall_left  = 0;
    stall_taken = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (long_stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left  = LONG_STALL - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [KEY_BITS-1:0]   fill_keys [KEY_SLOTS];
    logic [KEY_BITS-1:0]   key;
    logic [CHILD_BITS-1:0] child;
    logic [OP_W-1:0]       op;
    int                    sent;
    int                    r;
    fill_keys = '{16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
                  16'h1234, 16'h4321, 16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h00FF,
                  16'hFF00, 16'h0F0F};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty node, ignored op, fill to full with duplicates, split
    send_item(OP_INIT, '0, '0);
    send_item(OP_LOOKUP, 16'hFFFF, $urandom);
    send_item(OP_IGNORED, 16'hFFFF, '1);
    for (int i = 0; i < KEY_SLOTS; i++)
      send_item(OP_INSERT, fill_keys[i], (i == 0) ? '1 : (i == 1) ? '0 : $urandom);
    send_item(OP_LOOKUP, 16'h0000, '0);
    send_item(OP_LOOKUP, 16'hFFFF, '1);
    send_item(OP_INSERT, 16'h8000, '1);
    send_item(OP_LOOKUP, 16'h7FFF, $urandom);
    send_item(OP_INIT, '1, '1);
    send_item(OP_LOOKUP, 16'h0000, $urandom);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 50 : 0;
      rx_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 18 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (phase == 0 && sent == 30) long_stall_req = 1'b1;
        if (phase == 1 && sent == 60) drain_results();
        r = $urandom_range(99);
        if (r < 2)       op = OP_INIT;
        else if (r < 5)  op = OP_IGNORED;
        else if (r < 40) op = OP_LOOKUP;
        else             op = OP_INSERT;
        r = $urandom_range(9);
        if (r < 4)      key = 16'($urandom);
        else if (r < 9) key = 16'($urandom_range(24));
        else            key = 16'hFFFF - 16'($urandom_range(3));
        child = $urandom;
        send_item(op, key, child);
        if (op != OP_IGNORED) sent++;
      end
    end

    drain_results();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("btree_internal_node_engine_top verification clean");
    else
      $display("btree_internal_node_engine_top verification failed");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("btree_internal_node_engine_top verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bine_pkg.sv
sv/bine_store.sv
sv/bine_ctrl.sv
sv/btree_internal_node_engine_top.sv
verif/btree_internal_node_engine_checker.sv
verif/tb_btree_internal_node_engine_top.sv
